// File: src/ipc_pkg.sv
// shared types, constants and helper functions of the irrigation pump controller
`default_nettype none

package ipc_pkg;

  // field and register widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned CmdW     = 8;
  localparam int unsigned AdcW     = 10;
  localparam int unsigned EchoW    = 8;
  localparam int unsigned TpsW     = 10;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned ValW     = 8;
  localparam int unsigned TensW    = 5;
  localparam int unsigned OnesW    = 4;
  localparam int unsigned SegW     = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 10;

  // item kinds
  localparam logic [OpW-1:0] OpCommand = 3'd0;
  localparam logic [OpW-1:0] OpTick    = 3'd1;
  localparam logic [OpW-1:0] OpSample  = 3'd2;
  localparam logic [OpW-1:0] OpEcho    = 3'd3;
  localparam logic [OpW-1:0] OpButton  = 3'd4;

  // remote command characters
  localparam logic [CmdW-1:0] CmdToggleMode = 8'h41;
  localparam logic [CmdW-1:0] CmdToggleGate = 8'h42;
  localparam logic [CmdW-1:0] CmdStart      = 8'h43;
  localparam logic [CmdW-1:0] CmdTempUp     = 8'h44;
  localparam logic [CmdW-1:0] CmdTempDown   = 8'h45;
  localparam logic [CmdW-1:0] CmdHumiUp     = 8'h46;
  localparam logic [CmdW-1:0] CmdHumiDown   = 8'h47;
  localparam logic [CmdW-1:0] CmdSecUp      = 8'h48;
  localparam logic [CmdW-1:0] CmdSecDown    = 8'h49;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgTicks     = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgThreshold = 1'b1;

  // reset values and steps
  localparam logic [TpsW-1:0] TicksReset     = 10'd500;
  localparam logic [ThrW-1:0] ThresholdReset = 8'd50;
  localparam logic [ValW-1:0] SecondsReset   = 8'd30;
  localparam logic [ValW-1:0] TargetStep     = 8'd5;

  // sensor conversion constants
  localparam int unsigned     ScaledW    = AdcW + 8;
  localparam logic [7:0]      AdcScale   = 8'd250;
  localparam logic [ValW-1:0] TempOffset = 8'd75;
  localparam logic [ScaledW-1:0] HumiOffset = 18'd25600;

  // distance = floor(echo * 64 * 34300 / 2000000) = floor(echo * 1.0976)
  // rounded-up reciprocal in 20 fraction bits, exact for all 8-bit counts
  localparam int unsigned     DistMulW  = 21;
  localparam int unsigned     DistShift = 20;
  localparam logic [DistMulW-1:0] DistMul = 21'd1150918;
  localparam int unsigned     DistProdW = EchoW + DistMulW;

  // divide by ten of an 8-bit value: (x * 205) >> 11
  localparam logic [7:0] DivTenMul   = 8'd205;
  localparam int unsigned DivTenShift = 11;
  localparam logic [3:0] Ten         = 4'd10;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [CmdW-1:0]  cmd_byte;
    logic [AdcW-1:0]  temp_adc;
    logic [AdcW-1:0]  humi_adc;
    logic [EchoW-1:0] echo_count;
  } ipc_item_t;

  typedef struct packed {
    logic             pump_on;
    logic             auto_on;
    logic             gate_on;
    logic [TensW-1:0] tens_digit;
    logic [OnesW-1:0] ones_digit;
    logic [SegW-1:0]  tens_segments;
    logic [SegW-1:0]  ones_segments;
    logic [ValW-1:0]  temperature;
    logic [ValW-1:0]  humidity;
    logic [ValW-1:0]  distance;
  } ipc_result_t;

  typedef struct packed {
    logic countdown_running;
  } ipc_status_t;

  // seven-segment pattern, blank above nine
  function automatic logic [SegW-1:0] seg_pattern(input logic [TensW-1:0] digit);
    logic [SegW-1:0] pat;
    unique case (digit)
      5'd0:    pat = 7'h7E;
      5'd1:    pat = 7'h18;
      5'd2:    pat = 7'h6D;
      5'd3:    pat = 7'h3D;
      5'd4:    pat = 7'h1B;
      5'd5:    pat = 7'h37;
      5'd6:    pat = 7'h73;
      5'd7:    pat = 7'h1E;
      5'd8:    pat = 7'h7F;
      5'd9:    pat = 7'h3F;
      default: pat = '0;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// File: src/ipc_in_stage.sv
// input register stage with valid/ready handshake
`default_nettype none

module ipc_in_stage (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  ipc_pkg::ipc_item_t  item_i,
  input  wire                 adv_i,
  output logic                valid_o,
  output ipc_pkg::ipc_item_t  item_o
);
  import ipc_pkg::*;

  logic      valid_q, valid_d;
  ipc_item_t item_q;
  logic      take;

  // the stage frees up in the same cycle its item moves on
  assign in_ready_o = !valid_q || adv_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  // control flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// File: src/ipc_core.sv
// controller state and the single-pass event update and pump decision
`default_nettype none

module ipc_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          adv_i,
  input  ipc_pkg::ipc_item_t           item_i,
  input  wire  [ipc_pkg::TpsW-1:0]     ticks_per_second_i,
  input  wire  [ipc_pkg::ThrW-1:0]     distance_threshold_i,
  output ipc_pkg::ipc_result_t         result_o,
  output ipc_pkg::ipc_status_t         status_o
);
  import ipc_pkg::*;

  // state registers
  logic             auto_q, auto_d;
  logic             gate_q, gate_d;
  logic [ValW-1:0]  tgt_temp_q, tgt_temp_d;
  logic [ValW-1:0]  tgt_humi_q, tgt_humi_d;
  logic [ValW-1:0]  tgt_sec_q, tgt_sec_d;
  logic             running_q, running_d;
  logic [ValW-1:0]  elapsed_q, elapsed_d;
  logic [TensW-1:0] tens_q, tens_d;
  logic [OnesW-1:0] ones_q, ones_d;
  logic [TpsW-1:0]  tick_q, tick_d;
  logic             parity_q, parity_d;
  logic [AdcW-1:0]  temp_adc_q, temp_adc_d;
  logic [AdcW-1:0]  humi_adc_q, humi_adc_d;
  logic [ValW-1:0]  temp_q, temp_d;
  logic [ValW-1:0]  humi_q, humi_d;
  logic [ValW-1:0]  dist_q, dist_d;

  // datapath helpers
  logic [ScaledW-1:0]   temp_scaled;
  logic [ScaledW-1:0]   humi_scaled;
  logic [ValW-1:0]      temp_conv;
  logic [ValW-1:0]      humi_conv;
  logic [DistProdW-1:0] dist_prod;
  logic [8:0]           dist_raw;
  logic [ValW-1:0]      dist_conv;
  logic [TpsW-1:0]      tick_inc;
  logic [ValW-1:0]      elapsed_inc;
  logic [ValW-1:0]      left;
  logic [15:0]          div_prod;
  logic [TensW-1:0]     left_tens;
  logic [ValW-1:0]      left_rem;
  logic                 far;
  logic                 run;

  // sensor conversions in fixed point
  assign temp_scaled = temp_adc_q * AdcScale;
  assign humi_scaled = humi_adc_q * AdcScale;
  assign temp_conv   = (temp_scaled[ScaledW-1:10] >= TempOffset)
                       ? temp_scaled[ScaledW-1:10] - TempOffset : '0;
  assign humi_conv   = (humi_scaled >= HumiOffset)
                       ? ValW'((humi_scaled - HumiOffset) >> 11) : '0;

  // echo count to distance, saturated
  assign dist_prod = item_i.echo_count * DistMul;
  assign dist_raw  = dist_prod[DistProdW-1:DistShift];
  assign dist_conv = dist_raw[8] ? '1 : dist_raw[7:0];

  // countdown digits of the remaining seconds
  assign tick_inc    = tick_q + 1'b1;
  assign elapsed_inc = elapsed_q + 1'b1;
  assign left        = tgt_sec_q - elapsed_inc;
  assign div_prod    = left * DivTenMul;
  assign left_tens   = div_prod[15:DivTenShift];
  assign left_rem    = left - ValW'(left_tens) * ValW'(Ten);

  always_comb begin
    auto_d     = auto_q;
    gate_d     = gate_q;
    tgt_temp_d = tgt_temp_q;
    tgt_humi_d = tgt_humi_q;
    tgt_sec_d  = tgt_sec_q;
    running_d  = running_q;
    elapsed_d  = elapsed_q;
    tens_d     = tens_q;
    ones_d     = ones_q;
    tick_d     = tick_q;
    parity_d   = parity_q;
    temp_adc_d = temp_adc_q;
    humi_adc_d = humi_adc_q;
    temp_d     = temp_q;
    humi_d     = humi_q;
    dist_d     = dist_q;
    far        = 1'b0;
    run        = 1'b0;

    // event handling
    unique case (item_i.op)
      OpCommand: begin
        unique case (item_i.cmd_byte)
          CmdToggleMode: auto_d     = !auto_q;
          CmdToggleGate: gate_d     = !gate_q;
          CmdStart:      running_d  = 1'b1;
          CmdTempUp:     tgt_temp_d = tgt_temp_q + TargetStep;
          CmdTempDown:   tgt_temp_d = tgt_temp_q - TargetStep;
          CmdHumiUp:     tgt_humi_d = tgt_humi_q + TargetStep;
          CmdHumiDown:   tgt_humi_d = tgt_humi_q - TargetStep;
          CmdSecUp: begin
            if (!auto_q) tgt_sec_d = tgt_sec_q + 1'b1;
          end
          CmdSecDown: begin
            if (!auto_q) tgt_sec_d = tgt_sec_q - 1'b1;
          end
          default: ;
        endcase
      end
      OpTick: begin
        if (tick_inc < ticks_per_second_i) begin
          tick_d = tick_inc;
        end else begin
          tick_d   = '0;
          parity_d = !parity_q;
          // convert on every second second
          if (parity_q) begin
            temp_d = temp_conv;
            humi_d = humi_conv;
          end
          if (running_q) begin
            elapsed_d = elapsed_inc;
            tens_d    = left_tens;
            ones_d    = left_rem[OnesW-1:0];
          end
        end
      end
      OpSample: begin
        temp_adc_d = item_i.temp_adc;
        humi_adc_d = item_i.humi_adc;
      end
      OpEcho:   dist_d = dist_conv;
      OpButton: auto_d = !auto_q;
      default: ;
    endcase

    // pump decision on the updated state
    far = dist_d > distance_threshold_i;
    if (auto_d) begin
      run = (temp_d > tgt_temp_d) || (humi_d < tgt_humi_d);
      if (gate_d) run = run && far;
    end else if (running_d) begin
      if (elapsed_d >= tgt_sec_d) begin
        // countdown expired
        running_d = 1'b0;
        elapsed_d = '0;
        tens_d    = '0;
        ones_d    = '0;
        run       = 1'b0;
      end else begin
        run = gate_d ? far : 1'b1;
      end
    end else begin
      run = 1'b0;
    end
  end

  // state update when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q     <= 1'b0;
      gate_q     <= 1'b0;
      tgt_temp_q <= '0;
      tgt_humi_q <= '0;
      tgt_sec_q  <= SecondsReset;
      running_q  <= 1'b0;
      elapsed_q  <= '0;
      tens_q     <= '0;
      ones_q     <= '0;
      tick_q     <= '0;
      parity_q   <= 1'b0;
      temp_adc_q <= '0;
      humi_adc_q <= '0;
      temp_q     <= '0;
      humi_q     <= '0;
      dist_q     <= '0;
    end else if (adv_i) begin
      auto_q     <= auto_d;
      gate_q     <= gate_d;
      tgt_temp_q <= tgt_temp_d;
      tgt_humi_q <= tgt_humi_d;
      tgt_sec_q  <= tgt_sec_d;
      running_q  <= running_d;
      elapsed_q  <= elapsed_d;
      tens_q     <= tens_d;
      ones_q     <= ones_d;
      tick_q     <= tick_d;
      parity_q   <= parity_d;
      temp_adc_q <= temp_adc_d;
      humi_adc_q <= humi_adc_d;
      temp_q     <= temp_d;
      humi_q     <= humi_d;
      dist_q     <= dist_d;
    end
  end

  // result of this item, the pump flag is held in the result register
  always_comb begin
    result_o.pump_on       = run;
    result_o.auto_on       = auto_d;
    result_o.gate_on       = gate_d;
    result_o.tens_digit    = tens_d;
    result_o.ones_digit    = ones_d;
    result_o.tens_segments = seg_pattern(tens_d);
    result_o.ones_segments = seg_pattern({1'b0, ones_d});
    result_o.temperature   = temp_d;
    result_o.humidity      = humi_d;
    result_o.distance      = dist_d;
  end

  assign status_o.countdown_running = running_q;

endmodule

`default_nettype wire

// File: src/ipc_out_stage.sv
// result register with valid/ready handshake
`default_nettype none

module ipc_out_stage (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   item_valid_i,
  input  ipc_pkg::ipc_result_t  result_i,
  output logic                  adv_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output ipc_pkg::ipc_result_t  result_o
);
  import ipc_pkg::*;

  logic        valid_q, valid_d;
  ipc_result_t result_q;

  // an item moves on when the register is empty or being drained
  assign adv_o = item_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (adv_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// File: src/irrigation_pump_controller.sv
// top level of the irrigation pump controller
// pipeline: the item is held in the input register and its result in the result register
// throughput: one item per cycle while out_ready_i keeps up; the event update and pump
// decision form one short combinational pass between the input and result registers
// reset: asynchronous active low; mode, gate, targets, countdown, converted values and
// configuration return to their defaults, both stages empty
`default_nettype none

module irrigation_pump_controller (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire  [ipc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [ipc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  [ipc_pkg::OpW-1:0]          op_i,
  input  wire  [ipc_pkg::CmdW-1:0]         cmd_byte_i,
  input  wire  [ipc_pkg::AdcW-1:0]         temp_adc_i,
  input  wire  [ipc_pkg::AdcW-1:0]         humi_adc_i,
  input  wire  [ipc_pkg::EchoW-1:0]        echo_count_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output logic                             pump_on_o,
  output logic                             auto_on_o,
  output logic                             gate_on_o,
  output logic [ipc_pkg::TensW-1:0]        tens_digit_o,
  output logic [ipc_pkg::OnesW-1:0]        ones_digit_o,
  output logic [ipc_pkg::SegW-1:0]         tens_segments_o,
  output logic [ipc_pkg::SegW-1:0]         ones_segments_o,
  output logic [ipc_pkg::ValW-1:0]         temperature_o,
  output logic [ipc_pkg::ValW-1:0]         humidity_o,
  output logic [ipc_pkg::ValW-1:0]         distance_o
);
  import ipc_pkg::*;

  logic [TpsW-1:0] tps_q;
  logic [ThrW-1:0] thr_q;
  ipc_item_t       in_item;
  ipc_item_t       s1_item;
  logic            s1_valid;
  logic            adv;
  ipc_result_t     core_result;
  ipc_result_t     out_result;
  ipc_status_t     status;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TicksReset;
      thr_q <= ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTicks:     tps_q <= cfg_data_i[TpsW-1:0];
        CfgThreshold: thr_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // gather the input fields
  always_comb begin
    in_item.op         = op_i;
    in_item.cmd_byte   = cmd_byte_i;
    in_item.temp_adc   = temp_adc_i;
    in_item.humi_adc   = humi_adc_i;
    in_item.echo_count = echo_count_i;
  end

  ipc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ipc_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .adv_i                (adv),
    .item_i               (s1_item),
    .ticks_per_second_i   (tps_q),
    .distance_threshold_i (thr_q),
    .result_o             (core_result),
    .status_o             (status)
  );

  ipc_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_valid),
    .result_i     (core_result),
    .adv_o        (adv),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (out_result)
  );

  // result fields
  assign pump_on_o       = out_result.pump_on;
  assign auto_on_o       = out_result.auto_on;
  assign gate_on_o       = out_result.gate_on;
  assign tens_digit_o    = out_result.tens_digit;
  assign ones_digit_o    = out_result.ones_digit;
  assign tens_segments_o = out_result.tens_segments;
  assign ones_segments_o = out_result.ones_segments;
  assign temperature_o   = out_result.temperature;
  assign humidity_o      = out_result.humidity;
  assign distance_o      = out_result.distance;

  // a held input item is never dropped before it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid && !adv |=> s1_valid)
    else $error("input item lost while stalled");

  // manual-mode pump only runs during a countdown
  a_manual_pump: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pump_on_o && !auto_on_o |-> status.countdown_running)
    else $error("manual pump on without countdown");

  // tens digit of an 8-bit count stays within range and blanks above nine
  a_tens_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tens_digit_o > 5'd9 |-> tens_digit_o <= 5'd25 && tens_segments_o == '0)
    else $error("tens digit out of range");

endmodule

`default_nettype wire

// File: test/irrigation_pump_controller_tb.sv
// self-checking testbench of the irrigation pump controller, directed table then random scenes
module irrigation_pump_controller_tb;
  import ipc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportCap  = 200;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LongHold   = 80;

  // seven-segment glyphs, digit 0 in the low bits
  localparam logic [69:0] GlyphRom = {7'h3F, 7'h7F, 7'h1E, 7'h73, 7'h37,
                                      7'h1B, 7'h3D, 7'h6D, 7'h18, 7'h7E};
  // panel right after reset: everything low, both digits show zero
  localparam ipc_result_t BlankPanel = {3'b000, 5'd0, 4'd0, 7'h7E, 7'h7E, 8'd0, 8'd0, 8'd0};

  typedef enum int {RowItem, RowTyped, RowRegs} row_kind_e;
  typedef enum int {SinkOpen, SinkCoin, SinkSparse, SinkThrottle} sink_mode_e;
  typedef enum int {RunCountdown, ClimateCheck, GateProbe, LineNoise} scene_e;

  typedef struct {
    row_kind_e   kind;
    ipc_item_t   it;
    ipc_result_t want;
    int          tps;
    int          thr;
  } dir_row_t;

  typedef struct {
    int tps;
    int thr;
    int count;
    bit steady;
    bit squeeze;
  } phase_t;

  // block inputs, all known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [OpW-1:0] op = '0;
  logic [CmdW-1:0] cmd_byte = '0;
  logic [AdcW-1:0] temp_adc = '0;
  logic [AdcW-1:0] humi_adc = '0;
  logic [EchoW-1:0] echo_count = '0;
  logic out_ready = 1'b0;

  // block outputs
  logic in_ready_o, out_valid_o;
  logic pump_on_o, auto_on_o, gate_on_o;
  logic [TensW-1:0] tens_digit_o;
  logic [OnesW-1:0] ones_digit_o;
  logic [SegW-1:0] tens_segments_o, ones_segments_o;
  logic [ValW-1:0] temperature_o, humidity_o, distance_o;

  irrigation_pump_controller dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .op_i            (op),
    .cmd_byte_i      (cmd_byte),
    .temp_adc_i      (temp_adc),
    .humi_adc_i      (humi_adc),
    .echo_count_i    (echo_count),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .pump_on_o       (pump_on_o),
    .auto_on_o       (auto_on_o),
    .gate_on_o       (gate_on_o),
    .tens_digit_o    (tens_digit_o),
    .ones_digit_o    (ones_digit_o),
    .tens_segments_o (tens_segments_o),
    .ones_segments_o (ones_segments_o),
    .temperature_o   (temperature_o),
    .humidity_o      (humidity_o),
    .distance_o      (distance_o)
  );

  // controller state as the testbench tracks it
  logic [TpsW-1:0]  ticks_cfg = TicksReset;
  logic [ThrW-1:0]  thresh_cfg = ThresholdReset;
  logic             mode_auto = 1'b0;
  logic             gate_en = 1'b0;
  logic [7:0]       temp_goal = '0;
  logic [7:0]       humi_goal = '0;
  logic [7:0]       run_secs = 8'd30;
  logic             cd_active = 1'b0;
  logic [7:0]       secs_done = '0;
  logic [4:0]       disp_tens = '0;
  logic [3:0]       disp_ones = '0;
  logic [9:0]       tick_cnt = '0;
  logic             odd_second = 1'b0;
  logic [9:0]       held_temp_adc = '0;
  logic [9:0]       held_humi_adc = '0;
  logic [7:0]       temp_deg = '0;
  logic [7:0]       humi_pct = '0;
  logic [7:0]       dist_cm = '0;
  logic             pump_run = 1'b0;

  ipc_result_t pending_panels[$];
  bit          typed_pending = 1'b0;
  ipc_result_t typed_panel = BlankPanel;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;
  logic [CmdW-1:0] letters[9] = '{CmdToggleMode, CmdToggleGate, CmdStart, CmdTempUp,
                                  CmdTempDown, CmdHumiUp, CmdHumiDown, CmdSecUp, CmdSecDown};

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // apply one item to the tracked state and return the panel it leaves
  function automatic ipc_result_t advance_controller(input ipc_item_t it);
    ipc_result_t panel;
    logic [7:0]  left;
    int unsigned scaled;
    int unsigned dist_full;
    logic        far;
    case (it.op)
      OpCommand: begin
        case (it.cmd_byte)
          CmdToggleMode: mode_auto = ~mode_auto;
          CmdToggleGate: gate_en = ~gate_en;
          CmdStart:      cd_active = 1'b1;
          CmdTempUp:     temp_goal = temp_goal + 8'd5;
          CmdTempDown:   temp_goal = temp_goal - 8'd5;
          CmdHumiUp:     humi_goal = humi_goal + 8'd5;
          CmdHumiDown:   humi_goal = humi_goal - 8'd5;
          CmdSecUp:      if (!mode_auto) run_secs = run_secs + 8'd1;
          CmdSecDown:    if (!mode_auto) run_secs = run_secs - 8'd1;
          default: ;
        endcase
      end
      OpTick: begin
        tick_cnt = tick_cnt + 10'd1;
        if (tick_cnt >= ticks_cfg) begin
          tick_cnt = '0;
          // sensor values refresh every other second
          if (odd_second) begin
            odd_second = 1'b0;
            scaled = (32'(held_temp_adc) * 32'd250) >> 10;
            temp_deg = (scaled >= 32'd75) ? 8'(scaled - 32'd75) : 8'd0;
            scaled = 32'(held_humi_adc) * 32'd250;
            humi_pct = (scaled >= 32'd25600) ? 8'((scaled - 32'd25600) >> 11) : 8'd0;
          end else begin
            odd_second = 1'b1;
          end
          if (cd_active) begin
            secs_done = secs_done + 8'd1;
            left = run_secs - secs_done;
            disp_tens = 5'(left / 8'd10);
            disp_ones = 4'(left % 8'd10);
          end
        end
      end
      OpSample: begin
        held_temp_adc = it.temp_adc;
        held_humi_adc = it.humi_adc;
      end
      OpEcho: begin
        dist_full = 32'(it.echo_count) * 32'd64 * 32'd34300 / 32'd2000000;
        dist_cm = (dist_full > 32'd255) ? 8'd255 : 8'(dist_full);
      end
      OpButton: mode_auto = ~mode_auto;
      default: ;
    endcase

    // pump decision after every item
    far = dist_cm > thresh_cfg;
    if (mode_auto) begin
      pump_run = (temp_deg > temp_goal) || (humi_pct < humi_goal);
      if (gate_en) pump_run = pump_run && far;
    end else if (cd_active) begin
      if (secs_done >= run_secs) begin
        cd_active = 1'b0;
        secs_done = '0;
        disp_tens = '0;
        disp_ones = '0;
        pump_run = 1'b0;
      end else begin
        pump_run = gate_en ? far : 1'b1;
      end
    end else begin
      pump_run = 1'b0;
    end

    panel.pump_on       = pump_run;
    panel.auto_on       = mode_auto;
    panel.gate_on       = gate_en;
    panel.tens_digit    = disp_tens;
    panel.ones_digit    = disp_ones;
    panel.tens_segments = (disp_tens <= 5'd9) ? GlyphRom[7 * int'(disp_tens) +: 7] : 7'd0;
    panel.ones_segments = (disp_ones <= 4'd9) ? GlyphRom[7 * int'(disp_ones) +: 7] : 7'd0;
    panel.temperature   = temp_deg;
    panel.humidity      = humi_pct;
    panel.distance      = dist_cm;
    return panel;
  endfunction

  function automatic void match_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= ReportCap) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // item of the given kind with every field random
  function automatic ipc_item_t scramble_item(input logic [OpW-1:0] kind);
    ipc_item_t it;
    it.op         = kind;
    it.cmd_byte   = CmdW'($urandom);
    it.temp_adc   = AdcW'($urandom);
    it.humi_adc   = AdcW'($urandom);
    it.echo_count = EchoW'($urandom);
    return it;
  endfunction

  function automatic ipc_item_t command_item(input logic [CmdW-1:0] code);
    ipc_item_t it;
    it = scramble_item(OpCommand);
    it.cmd_byte = code;
    return it;
  endfunction

  function automatic dir_row_t item_row(input logic [OpW-1:0] kind, input logic [CmdW-1:0] c,
                                        input logic [AdcW-1:0] t, input logic [AdcW-1:0] h,
                                        input logic [EchoW-1:0] e);
    dir_row_t r;
    r.kind = RowItem;
    r.it   = '{op: kind, cmd_byte: c, temp_adc: t, humi_adc: h, echo_count: e};
    r.want = BlankPanel;
    r.tps  = 0;
    r.thr  = 0;
    return r;
  endfunction

  // scoreboard: transfers on both channels, sampled at the rising edge
  always @(posedge clk_i) begin : scoreboard
    ipc_result_t seen;
    ipc_result_t want;
    ipc_result_t model;
    if (rst_ni) begin
      if (out_valid_o && out_ready) begin
        seen = {pump_on_o, auto_on_o, gate_on_o, tens_digit_o, ones_digit_o,
                tens_segments_o, ones_segments_o, temperature_o, humidity_o, distance_o};
        if (pending_panels.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportCap) $error("result transfer with no expected panel pending");
        end else begin
          want = pending_panels.pop_front();
          match_field("pump_on", want.pump_on, seen.pump_on);
          match_field("auto_on", want.auto_on, seen.auto_on);
          match_field("gate_on", want.gate_on, seen.gate_on);
          match_field("tens_digit", want.tens_digit, seen.tens_digit);
          match_field("ones_digit", want.ones_digit, seen.ones_digit);
          match_field("tens_segments", want.tens_segments, seen.tens_segments);
          match_field("ones_segments", want.ones_segments, seen.ones_segments);
          match_field("temperature", want.temperature, seen.temperature);
          match_field("humidity", want.humidity, seen.humidity);
          match_field("distance", want.distance, seen.distance);
        end
      end
      if (in_valid && in_ready_o) begin
        model = advance_controller({op, cmd_byte, temp_adc, humi_adc, echo_count});
        pending_panels.push_back(typed_pending ? typed_panel : model);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    sink_mode_e mode;
    int         mode_left;
    int         hold_left;
    int         beat;
    mode = SinkOpen;
    mode_left = 0;
    hold_left = 0;
    beat = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = LongHold;
      end
      if (mode_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      beat++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          SinkOpen:   out_ready <= 1'b1;
          SinkCoin:   out_ready <= 1'($urandom_range(0, 1));
          SinkSparse: out_ready <= ($urandom_range(0, 3) == 0);
          default:    out_ready <= (beat % 3 == 0);
        endcase
      end
    end
  end

  // offer one item and hold it until the transfer, then pace the next one
  task automatic send_item(input ipc_item_t it);
    int gap;
    in_valid   <= 1'b1;
    op         <= it.op;
    cmd_byte   <= it.cmd_byte;
    temp_adc   <= it.temp_adc;
    humi_adc   <= it.humi_adc;
    echo_count <= it.echo_count;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    typed_pending = 1'b0;
    items_sent++;
    // bursts of random length with random gaps, none in steady phases
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  // stop offering and wait until every expected panel has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_panels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // both registers, written back to back while the block is idle
  task automatic program_regs(input logic [TpsW-1:0] tps, input logic [ThrW-1:0] thr);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgTicks;
    cfg_data <= CfgDataW'(tps);
    @(negedge clk_i);
    cfg_idx  <= CfgThreshold;
    cfg_data <= CfgDataW'(thr);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    ticks_cfg  = tps;
    thresh_cfg = thr;
  endtask

  // one random scene: mostly well-formed sequences, some noise
  task automatic play_scene();
    scene_e    pick;
    int        roll;
    int        n;
    ipc_item_t it;
    logic [CmdW-1:0] dir;
    roll = $urandom_range(0, 99);
    if (roll < 40) pick = RunCountdown;
    else if (roll < 70) pick = ClimateCheck;
    else if (roll < 85) pick = GateProbe;
    else pick = LineNoise;
    case (pick)
      RunCountdown: begin
        if ($urandom_range(0, 3) == 0) send_item(command_item(CmdToggleMode));
        // adjust the countdown length, now and then by a long sweep
        dir = $urandom_range(0, 1) ? CmdSecUp : CmdSecDown;
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
        repeat (n) send_item(command_item(dir));
        send_item(command_item(CmdStart));
        repeat ($urandom_range(0, 80)) begin
          if ($urandom_range(0, 5) == 0)
            send_item(scramble_item($urandom_range(0, 1) ? OpEcho : OpSample));
          else
            send_item(scramble_item(OpTick));
        end
      end
      ClimateCheck: begin
        send_item(scramble_item(OpSample));
        repeat ($urandom_range(0, 3)) send_item(command_item(letters[$urandom_range(3, 6)]));
        if ($urandom_range(0, 4) == 0) send_item(scramble_item(OpButton));
        repeat ($urandom_range(1, 8)) send_item(scramble_item(OpTick));
        if ($urandom_range(0, 1) == 0) send_item(scramble_item(OpEcho));
      end
      GateProbe: begin
        if ($urandom_range(0, 1) == 0) send_item(command_item(CmdToggleGate));
        repeat ($urandom_range(1, 4)) begin
          // echo counts that land right around the threshold
          it = scramble_item(OpEcho);
          n = int'(thresh_cfg) * 233 / 256 + int'($urandom_range(0, 6)) - 3;
          it.echo_count = (n < 0) ? 8'd0 : ((n > 255) ? 8'd255 : 8'(n));
          send_item(it);
          if ($urandom_range(0, 1) == 0) send_item(scramble_item(OpTick));
        end
      end
      default: begin
        repeat ($urandom_range(1, 5)) send_item(scramble_item(OpW'($urandom_range(0, 7))));
      end
    endcase
  endtask

  initial begin : stimulus
    dir_row_t script[$];
    dir_row_t r;
    phase_t   plan[6];
    int       phase_end;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table: extremes, every command, every kind of item
    r = item_row(OpCommand, 8'h00, 10'h3FF, 10'h3FF, 8'hFF);
    r.kind = RowTyped;
    script.push_back(r);
    r = item_row(OpCommand, 8'hFF, 10'h000, 10'h000, 8'h00);
    r.kind = RowTyped;
    script.push_back(r);
    r = item_row(OpEcho, 8'h00, 10'h000, 10'h000, 8'hFF);
    r.kind = RowTyped;
    r.want.distance = 8'd255;
    script.push_back(r);
    r = item_row(OpEcho, 8'hFF, 10'h3FF, 10'h3FF, 8'h00);
    r.kind = RowTyped;
    script.push_back(r);
    // just over and just at the default threshold
    script.push_back(item_row(OpEcho, 8'h00, 10'h000, 10'h000, 8'd47));
    script.push_back(item_row(OpCommand, CmdToggleGate, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdStart, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpEcho, 8'h00, 10'h000, 10'h000, 8'd46));
    script.push_back(item_row(OpCommand, CmdToggleGate, 10'h000, 10'h000, 8'h00));
    // targets wrap below zero and come back
    script.push_back(item_row(OpCommand, CmdTempDown, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdTempUp, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdHumiDown, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdHumiUp, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdSecDown, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdSecUp, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpSample, 8'h00, 10'h3FF, 10'h3FF, 8'h00));
    // zero ticks per second: every tick is a second
    r = item_row(OpTick, 8'h00, 10'h000, 10'h000, 8'h00);
    r.kind = RowRegs;
    r.tps = 0;
    r.thr = ThresholdReset;
    script.push_back(r);
    script.push_back(item_row(OpTick, 8'hFF, 10'h3FF, 10'h3FF, 8'hFF));
    script.push_back(item_row(OpTick, 8'h00, 10'h000, 10'h000, 8'h00));
    // lowest samples convert to zero after clamping
    script.push_back(item_row(OpSample, 8'h00, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpTick, 8'h00, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpTick, 8'h00, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpButton, 8'h00, 10'h000, 10'h000, 8'h00));
    script.push_back(item_row(OpCommand, CmdSecUp, 10'h000, 10'h000, 8'h00));
    // undefined item kinds
    script.push_back(item_row(3'd7, 8'hFF, 10'h3FF, 10'h3FF, 8'hFF));
    script.push_back(item_row(3'd5, 8'h41, 10'h155, 10'h2AA, 8'h55));
    script.push_back(item_row(OpCommand, CmdToggleMode, 10'h000, 10'h000, 8'h00));

    foreach (script[i]) begin
      if (script[i].kind == RowRegs) begin
        drain();
        program_regs(TpsW'(script[i].tps), ThrW'(script[i].thr));
        typed_pending = 1'b0;
        send_item(script[i].it);
      end else begin
        typed_pending = (script[i].kind == RowTyped);
        typed_panel = script[i].want;
        send_item(script[i].it);
      end
    end

    // random phases over several register settings, extremes among them
    plan[0] = '{1, 0, 300, 1'b0, 1'b0};
    plan[1] = '{2, 50, 300, 1'b1, 1'b1};
    plan[2] = '{1023, 255, 150, 1'b0, 1'b0};
    plan[3] = '{0, 128, 300, 1'b0, 1'b0};
    plan[4] = '{3, 255, 300, 1'b0, 1'b0};
    plan[5] = '{1, 20, 450, 1'b0, 1'b0};
    foreach (plan[p]) begin
      drain();
      program_regs(TpsW'(plan[p].tps), ThrW'(plan[p].thr));
      steady = plan[p].steady;
      burst_left = 0;
      // long result-side hold-off while items keep coming
      if (plan[p].squeeze) hold_request = 1'b1;
      phase_end = items_sent + plan[p].count;
      while (items_sent < phase_end) play_scene();
    end
    drain();

    if (mismatches == 0 && pending_panels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
